// ===== hdl/tsp_pkg.sv =====
// shared types, codes and sequence table for the tone sequence player
package tsp_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ALARM  = 3'd1;
  localparam logic [2:0] CMD_CHIME  = 3'd2;
  localparam logic [2:0] CMD_NOTIFY = 3'd3;
  localparam logic [2:0] CMD_SINGLE = 3'd4;
  localparam logic [2:0] CMD_STOP   = 3'd5;

  // sequence codes
  localparam logic [1:0] TUNE_ALARM  = 2'd0;
  localparam logic [1:0] TUNE_CHIME  = 2'd1;
  localparam logic [1:0] TUNE_NOTIFY = 2'd2;
  localparam logic [1:0] TUNE_SINGLE = 2'd3;

  // step indexes of the fixed table
  localparam logic [2:0] STEP_FIRST  = 3'd0;
  localparam logic [2:0] STEP_SECOND = 3'd1;
  localparam logic [2:0] STEP_THIRD  = 3'd2;
  localparam logic [2:0] STEP_FOURTH = 3'd3;

  // timing and pitch of the built-in sequences
  localparam logic [15:0] BEEP_FREQ_RESET = 16'd3200;
  localparam logic [15:0] ALARM_BEEP_MS   = 16'd120;
  localparam logic [15:0] ALARM_GAP_MS    = 16'd80;
  localparam logic [15:0] ALARM_PAUSE_MS  = 16'd680;
  localparam logic [15:0] CHIME_BEEP_MS   = 16'd60;
  localparam logic [15:0] NOTIFY_LOW_HZ   = 16'd2800;
  localparam logic [15:0] NOTIFY_HIGH_HZ  = 16'd3600;
  localparam logic [15:0] NOTIFY_TONE_MS  = 16'd70;

  // input beat
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] tone_freq;
    logic [15:0] tone_duration;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic        tone_on;
    logic [15:0] drive_freq;
    logic        busy_res;
  } out_beat_t;

  // one table step; zero length marks the end of a sequence
  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] len;
  } step_t;

  // table lookup of one step
  function automatic step_t step_lookup(input logic [1:0] seq, input logic [2:0] idx,
                                        input logic [15:0] beep, input logic [15:0] sfreq,
                                        input logic [15:0] slen);
    step_t s;
    s = '0;
    unique case (seq)
      TUNE_ALARM: begin
        if (idx == STEP_FIRST) begin
          s.freq = beep;
          s.len  = ALARM_BEEP_MS;
        end else if (idx == STEP_SECOND) begin
          s.len  = ALARM_GAP_MS;
        end else if (idx == STEP_THIRD) begin
          s.freq = beep;
          s.len  = ALARM_BEEP_MS;
        end else if (idx == STEP_FOURTH) begin
          s.len  = ALARM_PAUSE_MS;
        end
      end
      TUNE_CHIME: begin
        if (idx == STEP_FIRST) begin
          s.freq = beep;
          s.len  = CHIME_BEEP_MS;
        end
      end
      TUNE_NOTIFY: begin
        if (idx == STEP_FIRST) begin
          s.freq = NOTIFY_LOW_HZ;
          s.len  = NOTIFY_TONE_MS;
        end else if (idx == STEP_SECOND) begin
          s.freq = NOTIFY_HIGH_HZ;
          s.len  = NOTIFY_TONE_MS;
        end
      end
      default: begin
        if (idx == STEP_FIRST) begin
          s.freq = sfreq;
          s.len  = slen;
        end
      end
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/tone_sequence_player.sv =====
// tone sequence player: command decode, step timing and result buffering
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_data (beep frequency)
//   in       in         in_valid / in_stall  in_data (in_beat_t)
//   out      out        out_valid/out_stall  out_data (out_beat_t)
//
// one beat enters per cycle while not stalled; acceptance registers its result.
// the player state is updated by a single decode and table step at acceptance.
// rst is synchronous and returns the player to idle with beep frequency 3200 Hz.
// a two-entry result buffer lets one more beat in while the output stalls;
// in_stall rises only once both entries hold results.
module tone_sequence_player
  import tsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data
);

  // player state
  logic [15:0] beep_hz;
  logic        playing, playing_next;
  logic        repeat_flag, repeat_flag_next;
  logic [1:0]  which_sequence, which_sequence_next;
  logic [2:0]  step_index, step_index_next;
  logic [15:0] ms_left, ms_left_next;
  logic [15:0] single_freq, single_freq_next;
  logic [15:0] single_length, single_length_next;

  // result buffer
  logic        skid_valid;
  out_beat_t   skid_data;
  out_beat_t   result;

  logic        in_take, out_take, need_enter;
  logic [1:0]  seq_c;
  logic [2:0]  idx_c;
  logic        rep_c, play_c;
  logic [15:0] ms_c;
  step_t       step_a, step_b, step_out;

  assign in_stall  = skid_valid;
  assign in_take   = in_valid & ~in_stall;
  assign out_take  = out_valid & ~out_stall;

  // beep frequency register
  always_ff @(posedge clk) begin
    if (rst) begin
      beep_hz <= BEEP_FREQ_RESET;
    end else if (cfg_we) begin
      beep_hz <= cfg_data;
    end
  end

  // command decode ahead of entering a step
  always_comb begin
    seq_c              = which_sequence;
    idx_c              = step_index;
    rep_c              = repeat_flag;
    play_c             = playing;
    need_enter         = 1'b0;
    ms_c               = ms_left;
    single_freq_next   = single_freq;
    single_length_next = single_length;
    unique case (in_data.command)
      CMD_TICK: begin
        if (playing) begin
          if (ms_left > 16'd1) begin
            ms_c = ms_left - 16'd1;
          end else begin
            idx_c      = step_index + 3'd1;
            need_enter = 1'b1;
          end
        end
      end
      CMD_ALARM, CMD_CHIME, CMD_NOTIFY: begin
        priority if (in_data.command == CMD_ALARM) begin
          seq_c = TUNE_ALARM;
        end else if (in_data.command == CMD_CHIME) begin
          seq_c = TUNE_CHIME;
        end else begin
          seq_c = TUNE_NOTIFY;
        end
        rep_c      = (in_data.command == CMD_ALARM);
        idx_c      = STEP_FIRST;
        play_c     = 1'b1;
        need_enter = 1'b1;
      end
      CMD_SINGLE: begin
        if (in_data.tone_freq != 16'd0 && in_data.tone_duration != 16'd0) begin
          single_freq_next   = in_data.tone_freq;
          single_length_next = in_data.tone_duration;
          seq_c      = TUNE_SINGLE;
          rep_c      = 1'b0;
          idx_c      = STEP_FIRST;
          play_c     = 1'b1;
          need_enter = 1'b1;
        end
      end
      CMD_STOP: begin
        play_c = 1'b0;
        rep_c  = 1'b0;
        idx_c  = STEP_FIRST;
        ms_c   = 16'd0;
      end
      default: begin
      end
    endcase
  end

  // step entry: load the step length, wrap a looping sequence or halt at its end
  assign step_a = step_lookup(seq_c, idx_c, beep_hz, single_freq_next, single_length_next);
  assign step_b = step_lookup(seq_c, STEP_FIRST, beep_hz, single_freq_next,
                              single_length_next);

  always_comb begin
    playing_next        = play_c;
    repeat_flag_next    = rep_c;
    which_sequence_next = seq_c;
    step_index_next     = idx_c;
    ms_left_next        = ms_c;
    if (need_enter) begin
      if (step_a.len != 16'd0) begin
        ms_left_next = step_a.len;
      end else if (rep_c && step_b.len != 16'd0) begin
        step_index_next = STEP_FIRST;
        ms_left_next    = step_b.len;
      end else begin
        playing_next     = 1'b0;
        repeat_flag_next = 1'b0;
        step_index_next  = STEP_FIRST;
        ms_left_next     = 16'd0;
      end
    end
  end

  // result from the state after this beat
  assign step_out = step_lookup(which_sequence_next, step_index_next, beep_hz,
                                single_freq_next, single_length_next);

  always_comb begin
    result.drive_freq = playing_next ? step_out.freq : 16'd0;
    result.tone_on    = playing_next && (step_out.freq != 16'd0);
    result.busy_res   = playing_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      playing        <= 1'b0;
      repeat_flag    <= 1'b0;
      which_sequence <= TUNE_ALARM;
      step_index     <= STEP_FIRST;
      ms_left        <= 16'd0;
      single_freq    <= 16'd0;
      single_length  <= 16'd0;
    end else if (in_take) begin
      playing        <= playing_next;
      repeat_flag    <= repeat_flag_next;
      which_sequence <= which_sequence_next;
      step_index     <= step_index_next;
      ms_left        <= ms_left_next;
      single_freq    <= single_freq_next;
      single_length  <= single_length_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (in_take) begin
        out_data <= result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_take) begin
      if (out_valid) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= result;
        out_valid <= 1'b1;
      end
    end
  end

endmodule

// ===== verif/tone_sequence_checker.sv =====
// checker for the tone sequence player: tracks player state and compares result beats
module tone_sequence_checker
  import tsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_beat_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_beat_t   out_data,
  output int          mismatches,
  output int          in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  // player state as seen from the beats accepted so far
  logic [15:0] beep_hz;
  logic        running;
  logic        looping;
  logic [1:0]  seq_sel;
  logic [2:0]  step_no;
  logic [15:0] ms_remaining;
  logic [15:0] one_hz;
  logic [15:0] one_ms;

  // drive outputs predicted for accepted beats, oldest first
  out_beat_t   drive_queue[$];
  out_beat_t   want;

  // pitch and length of one step; zero length means past the end
  function automatic void table_step(input logic [1:0] sq, input logic [2:0] idx,
                                     output logic [15:0] hz, output logic [15:0] ms);
    hz = '0;
    ms = '0;
    case (sq)
      TUNE_ALARM: begin
        case (idx)
          STEP_FIRST, STEP_THIRD: begin
            hz = beep_hz;
            ms = ALARM_BEEP_MS;
          end
          STEP_SECOND: ms = ALARM_GAP_MS;
          STEP_FOURTH: ms = ALARM_PAUSE_MS;
          default: ;
        endcase
      end
      TUNE_CHIME: begin
        if (idx == STEP_FIRST) begin
          hz = beep_hz;
          ms = CHIME_BEEP_MS;
        end
      end
      TUNE_NOTIFY: begin
        if (idx == STEP_FIRST) begin
          hz = NOTIFY_LOW_HZ;
          ms = NOTIFY_TONE_MS;
        end else if (idx == STEP_SECOND) begin
          hz = NOTIFY_HIGH_HZ;
          ms = NOTIFY_TONE_MS;
        end
      end
      default: begin
        if (idx == STEP_FIRST) begin
          hz = one_hz;
          ms = one_ms;
        end
      end
    endcase
  endfunction

  function automatic void halt_playback();
    running      = 1'b0;
    looping      = 1'b0;
    step_no      = STEP_FIRST;
    ms_remaining = '0;
  endfunction

  // enter the current step, wrapping the alarm or stopping at the end
  function automatic void load_step();
    logic [15:0] hz;
    logic [15:0] ms;
    table_step(seq_sel, step_no, hz, ms);
    if (ms == '0) begin
      if (looping) begin
        step_no = STEP_FIRST;
        table_step(seq_sel, step_no, hz, ms);
      end
      if (ms == '0) begin
        halt_playback();
        return;
      end
    end
    ms_remaining = ms;
  endfunction

  function automatic void begin_tune(input logic [1:0] sq, input logic loop);
    seq_sel = sq;
    looping = loop;
    step_no = STEP_FIRST;
    running = 1'b1;
    load_step();
  endfunction

  // apply one input beat and work out the drive output that follows it
  function automatic out_beat_t advance_player(input in_beat_t b);
    logic [15:0] hz;
    logic [15:0] ms;
    out_beat_t   r;
    case (b.command)
      CMD_TICK: begin
        if (running) begin
          if (ms_remaining > 16'd1) begin
            ms_remaining = ms_remaining - 16'd1;
          end else begin
            step_no = step_no + 3'd1;
            load_step();
          end
        end
      end
      CMD_ALARM:  begin_tune(TUNE_ALARM, 1'b1);
      CMD_CHIME:  begin_tune(TUNE_CHIME, 1'b0);
      CMD_NOTIFY: begin_tune(TUNE_NOTIFY, 1'b0);
      CMD_SINGLE: begin
        if (b.tone_freq != '0 && b.tone_duration != '0) begin
          one_hz = b.tone_freq;
          one_ms = b.tone_duration;
          begin_tune(TUNE_SINGLE, 1'b0);
        end
      end
      CMD_STOP: halt_playback();
      default: ;
    endcase
    hz = '0;
    if (running) table_step(seq_sel, step_no, hz, ms);
    r.tone_on    = (hz != '0);
    r.drive_freq = hz;
    r.busy_res   = running;
    return r;
  endfunction

  // watch the channels: config writes, result compare, then new predictions
  always @(posedge clk) begin
    if (rst) begin
      beep_hz    = BEEP_FREQ_RESET;
      one_hz     = '0;
      one_ms     = '0;
      seq_sel    = TUNE_ALARM;
      halt_playback();
      drive_queue.delete();
      mismatches = 0;
      in_flight  = 0;
    end else begin
      if (cfg_we) beep_hz = cfg_data;
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          $error("result beat with nothing predicted: tone_on %0b drive_freq %0d busy_res %0b",
                 out_data.tone_on, out_data.drive_freq, out_data.busy_res);
          mismatches++;
        end else begin
          want = drive_queue.pop_front();
          if (out_data.tone_on !== want.tone_on) begin
            $error("tone_on: expected %0b, actual %0b", want.tone_on, out_data.tone_on);
            mismatches++;
          end
          if (out_data.drive_freq !== want.drive_freq) begin
            $error("drive_freq: expected %0d, actual %0d", want.drive_freq, out_data.drive_freq);
            mismatches++;
          end
          if (out_data.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, actual %0b", want.busy_res, out_data.busy_res);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) drive_queue.push_back(advance_player(in_data));
      in_flight = drive_queue.size();
    end
  end

endmodule

// ===== verif/tb_tone_sequence_player.sv =====
// testbench top for the tone sequence player: stimulus, stalls, watchdog and verdict
module tb_tone_sequence_player;
  timeunit 1ns;
  timeprecision 1ps;
  import tsp_pkg::*;

  // command codes the block does not use
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_BEATS  = 85;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 4;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;

  int mismatches;
  int in_flight;
  int burst_left   = 0;
  int beats_sent   = 0;
  int idle_cycles  = 0;
  int stall_mode   = 0;
  int stall_left   = 0;

  tone_sequence_player dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  tone_sequence_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls in stretches: none, light, half, heavy
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // watchdog on cycles where neither channel moves a beat
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one input beat, sent in bursts with random gaps between them
  task automatic send_beat(input logic [2:0] cmd, input logic [15:0] hz, input logic [15:0] ms);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, tone_freq: hz, tone_duration: ms};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    beats_sent++;
  endtask

  // millisecond ticks with junk in the unused fields
  task automatic send_ticks(input int n);
    repeat (n) send_beat(CMD_TICK, 16'($urandom), 16'($urandom));
  endtask

  // hold off until every predicted result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_beep(input logic [15:0] hz);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= hz;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // mostly complete sequences with random content, the rest interruptions and noise
  task automatic run_episode();
    int          kind;
    logic [15:0] hz;
    logic [15:0] ms;
    kind = $urandom_range(0, 99);
    hz   = 16'($urandom_range(1, 65535));
    ms   = 16'($urandom_range(1, 6));
    if (kind < 35) begin
      send_beat(CMD_SINGLE, hz, ms);
      send_ticks($urandom_range(0, ms + 2));
    end else if (kind < 45) begin
      send_beat(CMD_CHIME, 16'($urandom), 16'($urandom));
      send_ticks($urandom_range(55, 63));
    end else if (kind < 55) begin
      send_beat(CMD_NOTIFY, 16'($urandom), 16'($urandom));
      send_ticks($urandom_range(60, 145));
    end else if (kind < 63) begin
      send_beat(CMD_ALARM, 16'($urandom), 16'($urandom));
      send_ticks($urandom_range(0, 250));
      if ($urandom_range(0, 1) == 0) send_beat(CMD_STOP, 16'($urandom), 16'($urandom));
    end else if (kind < 75) begin
      // single tone over the full field range, zero fields now and then
      hz = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
      ms = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
      send_beat(CMD_SINGLE, hz, ms);
      send_ticks($urandom_range(0, 4));
      if ($urandom_range(0, 1) == 0) send_beat(CMD_STOP, 16'($urandom), 16'($urandom));
    end else begin
      send_beat(3'($urandom_range(CMD_TICK, CMD_SPARE_B)), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int          target;
    logic [15:0] beep;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: idle items, ignored single tones, end of step, restart, stop
    send_beat(CMD_TICK, 16'h0000, 16'h0000);
    send_beat(CMD_SPARE_A, 16'hFFFF, 16'hFFFF);
    send_beat(CMD_SPARE_B, 16'h0000, 16'hFFFF);
    send_beat(CMD_SINGLE, 16'h0000, 16'd5);
    send_beat(CMD_SINGLE, 16'd5, 16'h0000);
    send_beat(CMD_SINGLE, 16'h0000, 16'h0000);
    send_beat(CMD_STOP, 16'hFFFF, 16'h0000);
    send_beat(CMD_SINGLE, 16'hFFFF, 16'd1);
    send_ticks(1);
    send_beat(CMD_SINGLE, 16'd1, 16'd2);
    send_ticks(2);
    send_beat(CMD_CHIME, 16'h0000, 16'h0000);
    send_ticks(1);
    send_beat(CMD_NOTIFY, 16'hFFFF, 16'hFFFF);
    send_ticks(1);
    send_beat(CMD_SINGLE, 16'h0000, 16'd7);
    send_beat(CMD_STOP, 16'h0000, 16'hFFFF);
    send_beat(CMD_ALARM, 16'h0000, 16'h0000);
    send_ticks(1);
    send_beat(CMD_SINGLE, 16'hFFFF, 16'hFFFF);
    send_ticks(1);
    send_beat(CMD_SPARE_A, 16'h0000, 16'h0000);
    send_beat(CMD_STOP, 16'hFFFF, 16'hFFFF);

    // random phases, each under its own beep frequency
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0:       beep = 16'd1;
        1:       beep = 16'hFFFF;
        default: beep = 16'($urandom_range(1, 65535));
      endcase
      write_beep(beep);
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) run_episode();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
